// ===== design/kpsd_pkg.sv =====
// ---------------------------------------------------------------------------
// kpsd_pkg
// Shared types, constants and the key code encoder of the 4x2 keypad
// scanner with hold detection and auto-repeat.
// ---------------------------------------------------------------------------
package kpsd_pkg;

  localparam int ROW_W      = 4;
  localparam int COL_W      = 2;
  localparam int CODE_W     = 8;
  localparam int DELAY_W    = 15;
  localparam int INTERVAL_W = 8;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CODE_W-1:0] NO_KEY_CODE = 8'hFF;
  localparam logic [CODE_W-1:0] ROW0_CODE   = 8'h40;
  localparam logic [CODE_W-1:0] ROW1_CODE   = 8'h50;
  localparam logic [CODE_W-1:0] ROW2_CODE   = 8'h60;
  localparam logic [CODE_W-1:0] ROW3_CODE   = 8'h70;
  localparam logic [CODE_W-1:0] COL0_BITS   = 8'h02;
  localparam logic [CODE_W-1:0] COL1_BITS   = 8'h03;

  localparam logic [DELAY_W-1:0]    DELAY_RESET    = 15'd150;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_DELAY    = 2'd0,
    CFG_REPEAT_INTERVAL = 2'd1
  } cfg_index_t;

  function automatic logic [CODE_W-1:0] scan_code(input logic [ROW_W-1:0] rows,
                                                  input logic [COL_W-1:0] cols);
    logic [CODE_W-1:0] row_code;
    logic              row_hit;
    row_code = NO_KEY_CODE;
    row_hit  = 1'b1;
    if (!rows[0]) begin
      row_code = ROW0_CODE;
    end else if (!rows[1]) begin
      row_code = ROW1_CODE;
    end else if (!rows[2]) begin
      row_code = ROW2_CODE;
    end else if (!rows[3]) begin
      row_code = ROW3_CODE;
    end else begin
      row_hit = 1'b0;
    end
    if (!row_hit) begin
      return NO_KEY_CODE;
    end else if (!cols[0]) begin
      return row_code | COL0_BITS;
    end else if (!cols[1]) begin
      return row_code | COL1_BITS;
    end else begin
      return NO_KEY_CODE;
    end
  endfunction

endpackage

// ===== design/keypad_scan_debounce_autorepeat.sv =====
// ---------------------------------------------------------------------------
// keypad_scan_debounce_autorepeat
// Scans a 4x2 active-low key matrix once per word, counts how long a key
// is held and reports presses and auto-repeats into a software latch.
// ---------------------------------------------------------------------------
// One scan word is taken per clock cycle while in_stall is low, and its result
// word is registered in the output stage; a two-entry output stage keeps input
// flowing while a result waits. The repeat phase is tracked by an incremental
// counter, so after every configuration write a bit-serial remainder unit
// rebuilds it from the hold count, and input is stalled until it is done.
module keypad_scan_debounce_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kpsd_pkg::ROW_W-1:0]       row_lines_n,
  input  logic [kpsd_pkg::COL_W-1:0]       col_lines_n,
  input  logic                             clear_latch,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             report,
  output logic [kpsd_pkg::CODE_W-1:0]      scanned_code,
  output logic [kpsd_pkg::CODE_W-1:0]      latched_key,
  input  logic                             cfg_we,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kpsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kpsd_pkg::*;

  logic [DELAY_W-1:0]    repeat_delay;
  logic [INTERVAL_W-1:0] repeat_interval;

  logic [CODE_W-1:0]     previous_code;
  logic [HOLD_W-1:0]     hold_count;
  logic [INTERVAL_W-1:0] repeat_phase;
  logic [CODE_W-1:0]     key_latch;

  logic                  rc_load;
  logic                  rc_busy;
  logic [3:0]            rc_cnt;
  logic [HOLD_W-1:0]     rc_div;
  logic [INTERVAL_W-1:0] rc_rem;
  logic [INTERVAL_W:0]   rc_trial;
  logic [INTERVAL_W:0]   rc_rem_next;

  logic                  skid_valid;
  logic                  skid_report;
  logic [CODE_W-1:0]     skid_code;
  logic [CODE_W-1:0]     skid_latch;

  logic                  accept;
  logic                  out_take;
  logic [CODE_W-1:0]     code;
  logic [HOLD_W-1:0]     twice;
  logic [HOLD_W-1:0]     hold_inc;
  logic                  held;
  logic                  in_repeat;
  logic [INTERVAL_W:0]   phase_inc;
  logic [INTERVAL_W-1:0] phase_next;
  logic [HOLD_W-1:0]     hold_next;
  logic                  hit;
  logic [CODE_W-1:0]     latch_next;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid || rc_busy;
  assign twice    = {repeat_delay, 1'b0};

  always_comb begin
    code       = scan_code(row_lines_n, col_lines_n);
    hold_inc   = hold_count + 1'b1;
    held       = (code == previous_code) && (code != NO_KEY_CODE);
    in_repeat  = hold_count >= twice;
    phase_inc  = (hold_count == twice) ? 9'd1 : ({1'b0, repeat_phase} + 1'b1);
    hit        = 1'b0;
    phase_next = repeat_phase;
    hold_next  = hold_count;
    if (held) begin
      hold_next  = (hold_inc == {HOLD_W{1'b1}}) ? twice : hold_inc;
      phase_next = '0;
      if (!in_repeat) begin
        hit = (hold_inc == 16'd1) || (hold_inc == {1'b0, repeat_delay}) ||
              (hold_inc == twice);
      end else if (repeat_interval != '0) begin
        if (phase_inc == {1'b0, repeat_interval}) begin
          phase_next = '0;
        end else begin
          phase_next = phase_inc[INTERVAL_W-1:0];
        end
        hit = (phase_next == '0);
      end
    end else if (code != previous_code) begin
      hold_next  = '0;
      phase_next = '0;
    end
    latch_next = clear_latch ? NO_KEY_CODE : key_latch;
    if (hit) begin
      latch_next = code;
    end
  end

  always_comb begin
    rc_trial    = {rc_rem, rc_div[HOLD_W-1]};
    rc_rem_next = rc_trial;
    if (rc_trial >= {1'b0, repeat_interval}) begin
      rc_rem_next = rc_trial - {1'b0, repeat_interval};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= DELAY_RESET;
      repeat_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPEAT_DELAY:    repeat_delay    <= cfg_data[DELAY_W-1:0];
        CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_load <= 1'b0;
      rc_busy <= 1'b0;
      rc_cnt  <= '0;
    end else if (cfg_we) begin
      rc_load <= 1'b1;
      rc_busy <= 1'b1;
    end else if (rc_load) begin
      rc_load <= 1'b0;
      rc_cnt  <= '0;
    end else if (rc_busy) begin
      rc_cnt <= rc_cnt + 1'b1;
      if (rc_cnt == 4'd15) begin
        rc_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rc_load) begin
      rc_div <= (hold_count > twice) ? (hold_count - twice) : '0;
      rc_rem <= '0;
    end else if (rc_busy) begin
      rc_div <= {rc_div[HOLD_W-2:0], 1'b0};
      rc_rem <= rc_rem_next[INTERVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code <= NO_KEY_CODE;
      hold_count    <= '0;
      repeat_phase  <= '0;
      key_latch     <= NO_KEY_CODE;
    end else if (accept) begin
      previous_code <= code;
      hold_count    <= hold_next;
      repeat_phase  <= phase_next;
      key_latch     <= latch_next;
    end else if (rc_busy && !rc_load && (rc_cnt == 4'd15)) begin
      repeat_phase <= rc_rem_next[INTERVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || out_take) begin
        report       <= hit;
        scanned_code <= code;
        latched_key  <= latch_next;
      end else begin
        skid_report <= hit;
        skid_code   <= code;
        skid_latch  <= latch_next;
      end
    end else if (out_take && skid_valid) begin
      report       <= skid_report;
      scanned_code <= skid_code;
      latched_key  <= skid_latch;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Keypad scanner testbench
// Streams scan words into the 4x2 keypad scanner with random gaps and output
// stalls, predicts every result word from its own model of the hold counter,
// the repeat schedule and the software latch, and checks each field.
// Register settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kpsd_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
    logic             clr;
    logic             drain_first;
  } scan_word_t;

  typedef struct packed {
    logic              report;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] latched;
  } key_result_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ROW_W-1:0]      row_lines_n = '1;
  logic [COL_W-1:0]      col_lines_n = '1;
  logic                  clear_latch = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  report;
  logic [CODE_W-1:0]     scanned_code;
  logic [CODE_W-1:0]     latched_key;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scan_word_t  scan_queue[$];
  key_result_t expected_keys[$];
  scan_word_t  cur_word = '1;

  logic [DELAY_W-1:0]    delay_ticks;
  logic [INTERVAL_W-1:0] interval_ticks;
  logic [CODE_W-1:0]     last_code;
  logic [HOLD_W-1:0]     hold_ticks;
  logic [CODE_W-1:0]     latch_copy;

  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int words_queued = 0;
  int words_taken = 0;
  int fail_count = 0;
  int reports_due = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  keypad_scan_debounce_autorepeat DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row_lines_n  (row_lines_n),
    .col_lines_n  (col_lines_n),
    .clear_latch  (clear_latch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report       (report),
    .scanned_code (scanned_code),
    .latched_key  (latched_key),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CODE_W-1:0] key_code(logic [ROW_W-1:0] rows,
                                                 logic [COL_W-1:0] cols);
    logic [CODE_W-1:0] row_codes [ROW_W];
    logic [CODE_W-1:0] col_bits [COL_W];
    int r;
    int c;
    row_codes = '{ROW0_CODE, ROW1_CODE, ROW2_CODE, ROW3_CODE};
    col_bits = '{COL0_BITS, COL1_BITS};
    r = -1;
    c = -1;
    for (int b = ROW_W - 1; b >= 0; b--) if (!rows[b]) r = b;
    for (int b = COL_W - 1; b >= 0; b--) if (!cols[b]) c = b;
    if (r < 0 || c < 0) return NO_KEY_CODE;
    return row_codes[r] | col_bits[c];
  endfunction

  // One scan tick: hold counting, repeat schedule and latch update.
  task automatic next_key_result(input scan_word_t w);
    logic [CODE_W-1:0] code;
    int twice;
    int phase;
    logic hit;
    key_result_t res;
    code = key_code(w.rows, w.cols);
    twice = 2 * int'(delay_ticks);
    hit = 1'b0;
    if (w.clr) latch_copy = NO_KEY_CODE;
    if (code == last_code && code != NO_KEY_CODE) begin
      hold_ticks = hold_ticks + 1'b1;
      if (int'(hold_ticks) <= twice) begin
        hit = (hold_ticks == 1) || (int'(hold_ticks) == int'(delay_ticks)) ||
              (int'(hold_ticks) == twice);
      end else if (interval_ticks != 0) begin
        phase = (int'(hold_ticks) - twice) % int'(interval_ticks);
        hit = (phase == 0);
      end
      if (hit) latch_copy = code;
      if (hold_ticks == '1) begin
        hold_ticks = twice[HOLD_W-1:0];
      end
    end else if (code != last_code) begin
      hold_ticks = '0;
    end
    last_code = code;
    if (hit) reports_due++;
    res.report = hit;
    res.code = code;
    res.latched = latch_copy;
    expected_keys.push_back(res);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_count++;
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
  endtask

  // Driver: presents queued scan words, with a random gap before each one while idle_on is set.
  always @(posedge clk) begin : drive
    logic presenting;
    presenting = in_valid;
    if (rst) begin
      presenting = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_key_result(cur_word);
        words_taken++;
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (scan_queue.size() != 0 &&
                     !(scan_queue[0].drain_first && expected_keys.size() != 0)) begin
          cur_word = scan_queue.pop_front();
          presenting = 1'b1;
          gap_left = idle_on ? $urandom_range(0, 19) : 0;
        end
      end
    end
    in_valid <= presenting;
    row_lines_n <= cur_word.rows;
    col_lines_n <= cur_word.cols;
    clear_latch <= cur_word.clr;
  end

  // Monitor: checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin : watch
    key_result_t want;
    if (rst) begin
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          note_mismatch("unexpected result word, scanned_code", -1, scanned_code);
        end else begin
          want = expected_keys.pop_front();
          if (report !== want.report) note_mismatch("report", want.report, report);
          if (scanned_code !== want.code)
            note_mismatch("scanned_code", want.code, scanned_code);
          if (latched_key !== want.latched)
            note_mismatch("latched_key", want.latched, latched_key);
        end
        stall_left = idle_on ? $urandom_range(0, 19) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_keys.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [3:0] wiggle_low_priority(logic [3:0] v);
    logic [3:0] keep;
    logic found;
    keep = '0;
    found = 1'b0;
    for (int b = 0; b < 4; b++) begin
      if (!found) keep[b] = 1'b1;
      if (!v[b]) found = 1'b1;
    end
    return (v & keep) | (4'($urandom) & ~keep);
  endfunction

  function automatic void queue_word(logic [ROW_W-1:0] rows, logic [COL_W-1:0] cols,
                                     logic clr, logic drain = 1'b0);
    scan_word_t w;
    w.rows = rows;
    w.cols = cols;
    w.clr = clr;
    w.drain_first = drain;
    scan_queue.push_back(w);
    words_queued++;
  endfunction

  // Holds one key for a number of ticks; lines below the pressed key wander.
  function automatic void queue_hold(logic [ROW_W-1:0] rows, logic [COL_W-1:0] cols,
                                     int ticks, int clr_odds);
    logic [3:0] r4;
    logic [3:0] c4;
    for (int i = 0; i < ticks; i++) begin
      r4 = wiggle_low_priority(rows);
      c4 = wiggle_low_priority({2'b11, cols});
      queue_word(r4, c4[COL_W-1:0], clr_odds != 0 && $urandom_range(0, clr_odds - 1) == 0);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REPEAT_DELAY) delay_ticks = value;
    else if (idx == CFG_REPEAT_INTERVAL) interval_ticks = value[INTERVAL_W-1:0];
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || expected_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_repeat(input int d, input int iv);
    wait_idle();
    write_reg(CFG_REPEAT_DELAY, DELAY_W'(d));
    write_reg(CFG_REPEAT_INTERVAL, {7'($urandom), 8'(iv)});
  endtask

  initial begin : stimulus
    int d;
    int iv;
    int span;
    int n;
    int len;
    logic [3:0] r;
    logic [1:0] c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    delay_ticks = DELAY_RESET;
    interval_ticks = INTERVAL_RESET;
    last_code = NO_KEY_CODE;
    hold_ticks = '0;
    latch_copy = NO_KEY_CODE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings: every row and column, no row,
    // no column, held no-key, presses and latch clears.
    queue_word(4'hF, 2'h0, 1'b0);
    queue_word(4'h0, 2'h3, 1'b0);
    queue_word(4'hF, 2'h3, 1'b0);
    queue_word(4'hF, 2'h3, 1'b0);
    queue_word(4'h0, 2'h0, 1'b0);
    queue_word(4'h0, 2'h0, 1'b0);
    queue_word(4'hE, 2'h2, 1'b0);
    queue_word(4'h1, 2'h0, 1'b0);
    queue_word(4'h1, 2'h0, 1'b0);
    queue_word(4'h3, 2'h1, 1'b0);
    queue_word(4'h3, 2'h1, 1'b1);
    queue_word(4'h7, 2'h2, 1'b0);
    queue_word(4'h7, 2'h2, 1'b0);
    queue_word(4'h7, 2'h2, 1'b1);
    queue_word(4'h5, 2'h1, 1'b0, 1'b1);
    queue_word(4'hD, 2'h1, 1'b0);
    queue_word(4'h0, 2'h0, 1'b1);
    queue_word(4'hF, 2'h0, 1'b1);
    queue_word(4'h0, 2'h2, 1'b0);
    queue_word(4'h8, 2'h0, 1'b0);
    queue_word(4'h8, 2'h0, 1'b0);

    // Short delay and interval, then a change in the middle of a hold.
    set_repeat(2, 3);
    queue_word(4'hF, 2'h3, 1'b0);
    queue_hold(4'h0, 2'h0, 15, 0);
    set_repeat(1, 1);
    queue_hold(4'h0, 2'h0, 5, 0);

    // Zero delay, then zero interval.
    set_repeat(0, 4);
    queue_word(4'hF, 2'h3, 1'b0);
    queue_hold(4'h1, 2'h1, 12, 0);
    set_repeat(3, 0);
    queue_word(4'hF, 2'h3, 1'b0);
    queue_hold(4'h3, 2'h2, 15, 0);

    // Writes to unused indexes must leave the settings alone.
    wait_idle();
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    queue_hold(4'h3, 2'h2, 4, 0);
    set_repeat(32767, 255);
    queue_hold(4'h7, 2'h1, 20, 0);
    set_repeat(1, 255);
    queue_hold(4'h7, 2'h1, 20, 0);

    // Random segments: mostly held keys with random content, some noise.
    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(0, 7))
        0: begin d = 0; iv = $urandom_range(1, 6); end
        1: begin d = $urandom_range(1, 8); iv = 0; end
        2: begin d = $urandom_range(20, 40); iv = $urandom_range(1, 12); end
        3: begin d = $urandom_range(1, 8); iv = 255; end
        default: begin d = $urandom_range(1, 8); iv = $urandom_range(1, 6); end
      endcase
      set_repeat(d, iv);
      idle_on = ($urandom_range(0, 3) != 0);
      span = 2 * d + 3 * iv + 4;
      if (span > 120) span = 120;
      n = 0;
      while (n < 100) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_word(4'($urandom), 2'($urandom), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 40) == 0);
          n++;
        end else begin
          r = 4'($urandom);
          c = 2'($urandom);
          if (r == 4'hF) r[$urandom_range(0, 3)] = 1'b0;
          if (c == 2'h3) c[$urandom_range(0, 1)] = 1'b0;
          len = $urandom_range(1, span);
          queue_hold(r, c, len, 10);
          n += len;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d scan words across %0d register writes, with %0d key reports,",
             words_taken, reg_writes, reports_due);
    $display("covering zero, smallest and largest delays and intervals, stalls and clears.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
